>>> hdl/utf8dec_pkg.sv
// ============================================================================
// utf8dec_pkg
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// ============================================================================
package utf8dec_pkg;

    // Sequence phase codes.
    localparam logic [1:0] PH_LEAD = 2'd0;  // expecting a lead byte
    localparam logic [1:0] PH_ONE  = 2'd1;  // one continuation byte remains
    localparam logic [1:0] PH_TWO  = 2'd2;  // two continuation bytes remain

    // Upper nibbles of multi-byte lead bytes.
    localparam logic [3:0] LEAD2_LO = 4'hC;
    localparam logic [3:0] LEAD2_HI = 4'hD;
    localparam logic [3:0] LEAD3    = 4'hE;

    // Top two bits of a continuation byte.
    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam int unsigned CAP_W   = 9;   // capacity register width
    localparam int unsigned CODE_W  = 16;  // UCS-2 character width
    localparam int unsigned COUNT_W = 9;   // character count field width

    // Per-string decoding state apart from the character count.
    typedef struct packed {
        logic              halted;
        logic [1:0]        phase;
        logic [CODE_W-1:0] acc;
    } t_dec_state;

    // One result of a decoding step.
    typedef struct packed {
        logic               valid;
        logic               is_end;
        logic [CODE_W-1:0]  code_unit;
        logic [COUNT_W-1:0] char_count;
    } t_dec_result;

endpackage

>>> hdl/utf8_to_ucs2_stream_decoder.sv
// ============================================================================
// utf8_to_ucs2_stream_decoder
// Decodes a zero-terminated UTF-8 byte stream into UCS-2 characters.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one UTF-8 byte per item in s_tdata. Each ASCII
//   byte or completed two- or three-byte sequence gives one character item
//   on the master channel (tlast low). A zero byte gives an end item (tlast
//   high) with the string's character count and clears the string state.
//   Errors and a full capacity halt decoding until the zero byte.
//   The configuration channel writes the 9-bit character capacity; it is
//   always ready and should only be written while the block is idle.
//   A byte is held in the input register and its result is registered in
//   the output register. Throughput: one byte per cycle while the receiver
//   does not stall, set by the single decode step between the input
//   register and the output register.
//   Reset clears the string state and sets the capacity to MAX_CHARS.
//   While the receiver stalls, the result is held and the input register
//   still takes one more byte before s_tready falls.
// ============================================================================
module utf8_to_ucs2_stream_decoder
    import utf8dec_pkg::*;
#(
    parameter int unsigned MAX_CHARS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data,   // capacity_chars
    // Byte input.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] in_byte
    // Character output.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [15:0] code_unit, [24:16] char_count
    output logic        o_m_tlast     // is_end
);

    localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic [CAP_W-1:0]   r_capacity;
    t_dec_state         r_state;
    t_dec_state         n_state;
    logic [CNT_W-1:0]   r_produced;
    logic [CNT_W-1:0]   n_produced;
    t_dec_result        step_res;
    logic               r_out_valid;
    logic               r_out_end;
    logic [CODE_W-1:0]  r_out_code;
    logic [COUNT_W-1:0] r_out_count;
    logic               advance;

    // The decode stage moves when the output register is free or drains.
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(MAX_CHARS);
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // Decode step.
    utf8dec_step #(
        .MAX_CHARS (MAX_CHARS),
        .CNT_W     (CNT_W)
    ) u_step (
        .i_byte     (r_in_byte),
        .i_state    (r_state),
        .i_produced (r_produced),
        .i_capacity (r_capacity),
        .o_state    (n_state),
        .o_produced (n_produced),
        .o_result   (step_res)
    );

    // String state advances once per decoded byte, whether or not it gives an item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '0;
            r_produced <= '0;
        end else if (advance) begin
            r_state    <= n_state;
            r_produced <= n_produced;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_res.valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.valid) begin
            r_out_end   <= step_res.is_end;
            r_out_code  <= step_res.code_unit;
            r_out_count <= step_res.char_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_end;
    assign o_m_tdata  = {7'd0, r_out_count, r_out_code};

    // The count never passes the build-time maximum.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(MAX_CHARS) >= r_produced)
        else $error("character count exceeds maximum");

    // A terminator leaves a clean string state behind.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_byte == 8'd0) |=>
            (r_produced == '0 && r_state == '0))
        else $error("string state not cleared after terminator");

    // End items carry no character and character items carry no count.
    a_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (r_out_end ? (r_out_code == '0) : (r_out_count == '0)))
        else $error("result fields mixed between character and end items");

endmodule

>>> hdl/utf8dec_step.sv
// ============================================================================
// utf8dec_step
// Combinational decode of one byte: next string state and optional result.
// ============================================================================
module utf8dec_step
    import utf8dec_pkg::*;
#(
    parameter int unsigned MAX_CHARS = 256,
    parameter int unsigned CNT_W     = 9
) (
    input  logic [7:0]       i_byte,
    input  t_dec_state       i_state,
    input  logic [CNT_W-1:0] i_produced,
    input  logic [CAP_W-1:0] i_capacity,
    output t_dec_state       o_state,
    output logic [CNT_W-1:0] o_produced,
    output t_dec_result      o_result
);

    // Comparison width covers both the count and the capacity register.
    localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_CHARS);

    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_eff;
    logic [CMP_W-1:0]  prod_ext;
    logic              full;
    logic [CODE_W-1:0] acc_sum;

    // Effective capacity is the register clamped to the build-time maximum.
    assign cap_ext  = CMP_W'(i_capacity);
    assign cap_eff  = (cap_ext < MAX_EXT) ? cap_ext : MAX_EXT;
    assign prod_ext = CMP_W'(i_produced);
    assign full     = (prod_ext >= cap_eff);
    assign acc_sum  = i_state.acc + {{(CODE_W-6){1'b0}}, i_byte[5:0]};

    // Next-state and result selection for one byte.
    always_comb begin
        o_state    = i_state;
        o_produced = i_produced;
        o_result   = '0;
        priority if (i_byte == 8'd0) begin
            // The terminator always ends the string and reports the count.
            o_result.valid      = 1'b1;
            o_result.is_end     = 1'b1;
            o_result.char_count = prod_ext[COUNT_W-1:0];
            o_state             = '0;
            o_produced          = '0;
        end else if (i_state.halted) begin
            // Bytes after a halt are dropped until the terminator.
        end else if (i_state.phase == PH_ONE || i_state.phase == PH_TWO) begin
            if (i_byte[7:6] != CONT_TAG) begin
                o_state.halted = 1'b1;
            end else if (i_state.phase == PH_TWO) begin
                o_state.acc   = {acc_sum[CODE_W-7:0], 6'd0};
                o_state.phase = PH_ONE;
            end else begin
                o_state.acc        = acc_sum;
                o_state.phase      = PH_LEAD;
                o_produced         = i_produced + CNT_W'(1);
                o_result.valid     = 1'b1;
                o_result.code_unit = acc_sum;
            end
        end else begin
            o_state.phase = PH_LEAD;
            if (full) begin
                o_state.halted = 1'b1;
            end else if (!i_byte[7]) begin
                o_produced         = i_produced + CNT_W'(1);
                o_result.valid     = 1'b1;
                o_result.code_unit = {8'd0, i_byte};
            end else begin
                unique case (i_byte[7:4])
                    LEAD2_LO, LEAD2_HI: begin
                        o_state.acc   = {5'd0, i_byte[4:0], 6'd0};
                        o_state.phase = PH_ONE;
                    end
                    LEAD3: begin
                        o_state.acc   = {4'd0, i_byte[3:0], 6'd0};
                        o_state.phase = PH_TWO;
                    end
                    default: begin
                        // Stray continuation or a four-byte lead.
                        o_state.halted = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule
